@@ sv/fbpa_pkg.sv @@
// Shared constants, codes and types of the fixed block pool allocator.
`timescale 1ns / 1ps
package fbpa_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_W     = 32;
	localparam int BB_W       = 17;
	localparam int BC_W       = 11;
	localparam int STAT_W     = 3;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_W      = 32;
	localparam int PROD_W     = CNT_W + BB_W;
	localparam int WIDE_W     = (ADDR_W > PROD_W) ? ADDR_W : PROD_W;
	localparam int ECW        = (CNT_W > BC_W) ? CNT_W : BC_W;
	localparam int STEP_W     = $clog2(IDX_W + 1);

	localparam logic [BB_W-1:0] BB_RESET = BB_W'(64);
	localparam logic [BC_W-1:0] BC_RESET = BC_W'(1024);

	// result status codes
	localparam logic [STAT_W-1:0] RS_ALLOC    = 3'd0;
	localparam logic [STAT_W-1:0] RS_FREED    = 3'd1;
	localparam logic [STAT_W-1:0] RS_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] RS_BAD      = 3'd3;
	localparam logic [STAT_W-1:0] RS_OVERFLOW = 3'd4;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;

	typedef struct packed {
		logic done;
		logic exact;
	} div_stat_t;

endpackage

@@ sv/fbpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/fbpa_div.sv @@
// Iterative restoring divider: block index and remainder test of a pool offset.
`timescale 1ns / 1ps
module fbpa_div
	import fbpa_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
	input  logic [fbpa_pkg::BB_W-1:0]   divisor,
	output logic [fbpa_pkg::IDX_W-1:0]  quotient,
	output fbpa_pkg::div_stat_t         stat
);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WIDE_W-1:0] rem_q;
	logic [WIDE_W-1:0] dsr_q;
	logic [IDX_W-1:0]  quo_q;
	logic              ge;

	// quotient is known to fit IDX_W bits: caller has checked offset < span
	assign ge = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && step_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= WIDE_W'(dividend);
			dsr_q  <= WIDE_W'(divisor) << (IDX_W - 1);
			step_q <= STEP_W'(IDX_W - 1);
			quo_q  <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q  <= dsr_q >> 1;
			step_q <= step_q - STEP_W'(1);
			quo_q  <= (quo_q << 1) | IDX_W'(ge);
		end
	end

	assign quotient   = quo_q;
	assign stat.done  = done_q;
	assign stat.exact = (rem_q == '0);

endmodule

@@ sv/fixed_block_pool_allocator_core.sv @@
// Top level: configuration, free-list sequencer, shared multiplier and next-link memory.
//
//  channel   handshake          payload
//  --------  -----------------  --------------------------------------
//  command   start / busy       func, address
//  result    done (strobe)      block_address, status
//  config    cfg_we             cfg_index, cfg_wdata
//
// Allocate from never-used blocks or the free list: the result passes through S_MUL and S_ADDR.
// Allocate on an empty pool: result in the cycle after accept.
// Free outside the pool or with zero block size: result after S_SPAN and S_CHECK; any other
// free also waits in S_DIV for the divider, which yields one quotient bit per cycle.
// Reset clears the list pointers and counts; next-link memory needs no clearing.
// Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
module fixed_block_pool_allocator_core
	import fbpa_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [fbpa_pkg::ADDR_W-1:0]    address,
	output logic                           done,
	output logic [fbpa_pkg::ADDR_W-1:0]    block_address,
	output logic [fbpa_pkg::STAT_W-1:0]    status,
	input  logic                           cfg_we,
	input  logic [fbpa_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SPAN  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_ADDR  = 3'd5;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] base_q;
	logic [BB_W-1:0]   bb_q;
	logic [BC_W-1:0]   bc_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  list_count_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [IDX_W-1:0]  idx_q;
	logic              upd_head_q;
	logic [ADDR_W-1:0] offset_q;
	logic [PROD_W-1:0] prod_q;
	logic              done_q;
	logic [ADDR_W-1:0] block_address_q;
	logic [STAT_W-1:0] status_q;

	logic [ECW-1:0]    bc_ext;
	logic [CNT_W-1:0]  eff_cnt;
	logic [CNT_W-1:0]  mul_a;
	logic              accept;
	logic              div_start;
	logic [IDX_W-1:0]  div_q;
	div_stat_t         div_stat;
	logic              link_we;
	logic [IDX_W-1:0]  link_rdata;

	assign bc_ext  = ECW'(bc_q);
	assign eff_cnt = (bc_ext > ECW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bc_ext);
	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);

	// one multiplier: pool span on a free, block offset on an allocate
	assign mul_a = (state_q == S_SPAN) ? eff_cnt : CNT_W'(idx_q);

	assign div_start = (state_q == S_CHECK) && (bb_q != '0)
	                   && (WIDE_W'(offset_q) < WIDE_W'(prod_q));

	assign link_we = (state_q == S_DIV) && div_stat.done && div_stat.exact
	                 && (list_count_q < fresh_q) && (list_count_q != '0);

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (offset_q),
		.divisor  (bb_q),
		.quotient (div_q),
		.stat     (div_stat)
	);

	fbpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (tail_q),
		.wdata (div_q),
		.re    (accept),
		.raddr (head_q),
		.rdata (link_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			bb_q   <= BB_RESET;
			bc_q   <= BC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_BASE:   base_q <= cfg_wdata[ADDR_W-1:0];
				REG_BLOCK_BYTES: bb_q   <= cfg_wdata[BB_W-1:0];
				REG_BLOCK_COUNT: bc_q   <= cfg_wdata[BC_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			list_count_q <= '0;
			fresh_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func != FUNC_ALLOC) begin
							state_q <= S_SPAN;
						end else if (fresh_q < eff_cnt) begin
							fresh_q <= fresh_q + CNT_W'(1);
							state_q <= S_MUL;
						end else if (list_count_q != '0) begin
							list_count_q <= list_count_q - CNT_W'(1);
							state_q      <= S_MUL;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_SPAN: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (div_stat.exact && list_count_q < fresh_q) begin
							if (list_count_q == '0) begin
								head_q <= div_q;
							end
							tail_q       <= div_q;
							list_count_q <= list_count_q + CNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					if (upd_head_q) begin
						head_q <= link_rdata;
					end
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			offset_q   <= address - base_q;
			upd_head_q <= 1'b0;
			if (fresh_q < eff_cnt) begin
				idx_q <= IDX_W'(fresh_q);
			end else begin
				idx_q      <= head_q;
				upd_head_q <= (list_count_q > CNT_W'(1));
			end
			if (func == FUNC_ALLOC && fresh_q >= eff_cnt && list_count_q == '0) begin
				block_address_q <= '0;
				status_q        <= RS_EMPTY;
			end
		end
		if (state_q == S_SPAN || state_q == S_MUL) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(bb_q);
		end
		if (state_q == S_CHECK && !div_start) begin
			block_address_q <= '0;
			status_q        <= RS_BAD;
		end
		if (state_q == S_DIV && div_stat.done) begin
			block_address_q <= '0;
			if (!div_stat.exact) begin
				status_q <= RS_BAD;
			end else if (list_count_q >= fresh_q) begin
				status_q <= RS_OVERFLOW;
			end else begin
				status_q <= RS_FREED;
			end
		end
		if (state_q == S_ADDR) begin
			block_address_q <= base_q + ADDR_W'(prod_q);
			status_q        <= RS_ALLOC;
		end
	end

	assign done          = done_q;
	assign block_address = block_address_q;
	assign status        = status_q;

endmodule
